// ===== rtl/connection_admission_limiter_top_macros.svh =====
// Assertion macros for the connection admission limiter checker.
`ifndef CONNECTION_ADMISSION_LIMITER_TOP_MACROS_SVH
`define CONNECTION_ADMISSION_LIMITER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CAL_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: check failed");
// Implication whose consequence is checked in the following cycle.
`define CAL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: check failed");
`endif

// ===== rtl/cal_pkg.sv =====
// Shared types, codes and constants for the connection admission limiter.
package cal_pkg;
   localparam int COUNT_TABLE_DEPTH_DEF = 64;
   localparam int ALLOW_DEPTH_DEF       = 16;
   localparam int DENY_DEPTH_DEF        = 16;
   localparam int CNT_W                 = 16;
   localparam int ADDR_W                = 32;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [2:0] {
      OP_OPEN         = 3'd0,
      OP_CLOSE        = 3'd1,
      OP_ALLOW_ADD    = 3'd2,
      OP_ALLOW_REMOVE = 3'd3,
      OP_DENY_ADD     = 3'd4,
      OP_DENY_REMOVE  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TOTAL_OVER  = 3'd1,
      ST_ADDR_OVER   = 3'd2,
      ST_DENIED      = 3'd3,
      ST_TABLE_FULL  = 3'd4,
      ST_NOT_FOUND   = 3'd5
   } status_type;

   localparam logic CSR_MAX_TOTAL = 1'b0;
   localparam logic CSR_MAX_PER   = 1'b1;

   // Controller to datapath commands.
   typedef struct packed {
      logic start;    // latch request, clear scan state
      logic scan;     // step scan index, compare one entry of each table
      logic finish;   // commit updates and build the response
   } cal_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;
   } cal_sts_type;
endpackage

// ===== rtl/cal_datapath.sv =====
// Datapath: tables, scan comparators, counters and response register.
module cal_datapath
   import cal_pkg::*;
#(
   parameter int COUNT_TABLE_DEPTH = COUNT_TABLE_DEPTH_DEF,
   parameter int ALLOW_DEPTH       = ALLOW_DEPTH_DEF,
   parameter int DENY_DEPTH        = DENY_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cal_cmd_type       cmd,
   output cal_sts_type       sts,
   input  logic [2:0]        req_op,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [CNT_W-1:0]  max_total,
   input  logic [CNT_W-1:0]  max_per,
   output logic              out_accepted,
   output logic [2:0]        out_status,
   output logic [CNT_W-1:0]  out_total,
   output logic [CNT_W-1:0]  out_addr_count
);
   localparam int CI_W  = (COUNT_TABLE_DEPTH > 1) ? $clog2(COUNT_TABLE_DEPTH) : 1;
   localparam int AI_W  = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
   localparam int DI_W  = (DENY_DEPTH > 1) ? $clog2(DENY_DEPTH) : 1;
   localparam int MAXD  = (COUNT_TABLE_DEPTH > ALLOW_DEPTH) ?
                          ((COUNT_TABLE_DEPTH > DENY_DEPTH) ? COUNT_TABLE_DEPTH : DENY_DEPTH) :
                          ((ALLOW_DEPTH > DENY_DEPTH) ? ALLOW_DEPTH : DENY_DEPTH);
   localparam int SI_W  = $clog2(MAXD + 2);

   // count table memory (keys, values), valid bits in flops
   logic [ADDR_W-1:0] ckey_mem [COUNT_TABLE_DEPTH];
   logic [CNT_W-1:0]  cval_mem [COUNT_TABLE_DEPTH];
   logic [COUNT_TABLE_DEPTH-1:0] cvalid_ff;
   logic [ADDR_W-1:0] akey_mem [ALLOW_DEPTH];
   logic [ALLOW_DEPTH-1:0] avalid_ff;
   logic [ADDR_W-1:0] dkey_mem [DENY_DEPTH];
   logic [DENY_DEPTH-1:0] dvalid_ff;

   logic [CNT_W-1:0]  total_ff;
   logic [2:0]        op_ff;
   logic [ADDR_W-1:0] addr_ff;

   // scan state: address issued this cycle, read data valid next
   logic [SI_W-1:0]   idx_ff;
   logic              rd_vld_ff;
   logic [SI_W-1:0]   rd_idx_ff;
   logic [ADDR_W-1:0] ckey_rd_ff, akey_rd_ff, dkey_rd_ff;
   logic [CNT_W-1:0]  cval_rd_ff;

   logic              c_hit_ff, c_free_ff, a_hit_ff, a_free_ff, d_hit_ff, d_free_ff;
   logic [CI_W-1:0]   c_hidx_ff, c_fidx_ff;
   logic [AI_W-1:0]   a_hidx_ff, a_fidx_ff;
   logic [DI_W-1:0]   d_hidx_ff, d_fidx_ff;
   logic [CNT_W-1:0]  c_hval_ff;

   assign sts.scan_done = (idx_ff == SI_W'(MAXD + 1));

   // memory reads, registered; reads past a table's end are ignored by the scan
   always_ff @(posedge clock) begin
      ckey_rd_ff <= ckey_mem[idx_ff[CI_W-1:0]];
      cval_rd_ff <= cval_mem[idx_ff[CI_W-1:0]];
      akey_rd_ff <= akey_mem[idx_ff[AI_W-1:0]];
      dkey_rd_ff <= dkey_mem[idx_ff[DI_W-1:0]];
   end

   // response computation
   logic [CNT_W-1:0] tot_inc, tot_dec, cv_inc, cv_dec;
   logic             per_on;
   assign per_on  = (max_per != '0);
   assign tot_inc = (total_ff != CNT_MAX) ? total_ff + 1'b1 : total_ff;
   assign tot_dec = (total_ff != '0) ? total_ff - 1'b1 : total_ff;
   assign cv_inc  = (c_hval_ff != CNT_MAX) ? c_hval_ff + 1'b1 : c_hval_ff;
   assign cv_dec  = (c_hval_ff != '0) ? c_hval_ff - 1'b1 : c_hval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= '0;
         avalid_ff <= '0;
         dvalid_ff <= '0;
         total_ff  <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            idx_ff    <= '0;
            rd_vld_ff <= 1'b0;
            op_ff     <= req_op;
            addr_ff   <= req_addr;
            c_hit_ff  <= 1'b0; c_free_ff <= 1'b0;
            a_hit_ff  <= 1'b0; a_free_ff <= 1'b0;
            d_hit_ff  <= 1'b0; d_free_ff <= 1'b0;
         end
         if (cmd.scan) begin
            idx_ff    <= idx_ff + 1'b1;
            rd_vld_ff <= 1'b1;
            rd_idx_ff <= idx_ff;
            if (rd_vld_ff) begin
               if (rd_idx_ff < SI_W'(COUNT_TABLE_DEPTH)) begin
                  if (cvalid_ff[rd_idx_ff[CI_W-1:0]] && ckey_rd_ff == addr_ff && !c_hit_ff) begin
                     c_hit_ff  <= 1'b1;
                     c_hidx_ff <= rd_idx_ff[CI_W-1:0];
                     c_hval_ff <= cval_rd_ff;
                  end
                  if (!cvalid_ff[rd_idx_ff[CI_W-1:0]] && !c_free_ff) begin
                     c_free_ff <= 1'b1;
                     c_fidx_ff <= rd_idx_ff[CI_W-1:0];
                  end
               end
               if (rd_idx_ff < SI_W'(ALLOW_DEPTH)) begin
                  if (avalid_ff[rd_idx_ff[AI_W-1:0]] && akey_rd_ff == addr_ff && !a_hit_ff) begin
                     a_hit_ff  <= 1'b1;
                     a_hidx_ff <= rd_idx_ff[AI_W-1:0];
                  end
                  if (!avalid_ff[rd_idx_ff[AI_W-1:0]] && !a_free_ff) begin
                     a_free_ff <= 1'b1;
                     a_fidx_ff <= rd_idx_ff[AI_W-1:0];
                  end
               end
               if (rd_idx_ff < SI_W'(DENY_DEPTH)) begin
                  if (dvalid_ff[rd_idx_ff[DI_W-1:0]] && dkey_rd_ff == addr_ff && !d_hit_ff) begin
                     d_hit_ff  <= 1'b1;
                     d_hidx_ff <= rd_idx_ff[DI_W-1:0];
                  end
                  if (!dvalid_ff[rd_idx_ff[DI_W-1:0]] && !d_free_ff) begin
                     d_free_ff <= 1'b1;
                     d_fidx_ff <= rd_idx_ff[DI_W-1:0];
                  end
               end
            end
         end
         if (cmd.finish) begin
            case (op_ff)
               OP_OPEN: begin
                  total_ff <= tot_inc;
                  if (per_on && !c_hit_ff && c_free_ff) cvalid_ff[c_fidx_ff] <= 1'b1;
               end
               OP_CLOSE: begin
                  total_ff <= tot_dec;
                  if (per_on && c_hit_ff && cv_dec == '0) cvalid_ff[c_hidx_ff] <= 1'b0;
               end
               OP_ALLOW_ADD:
                  if (!a_hit_ff && a_free_ff) avalid_ff[a_fidx_ff] <= 1'b1;
               OP_ALLOW_REMOVE:
                  if (a_hit_ff) avalid_ff[a_hidx_ff] <= 1'b0;
               OP_DENY_ADD:
                  if (!d_hit_ff && d_free_ff) dvalid_ff[d_fidx_ff] <= 1'b1;
               OP_DENY_REMOVE:
                  if (d_hit_ff) dvalid_ff[d_hidx_ff] <= 1'b0;
               default: ;
            endcase
         end
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (op_ff == OP_OPEN && per_on) begin
            if (c_hit_ff) cval_mem[c_hidx_ff] <= cv_inc;
            else if (c_free_ff) begin
               ckey_mem[c_fidx_ff] <= addr_ff;
               cval_mem[c_fidx_ff] <= CNT_W'(1);
            end
         end else if (op_ff == OP_CLOSE && per_on && c_hit_ff) begin
            cval_mem[c_hidx_ff] <= cv_dec;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.finish && op_ff == OP_ALLOW_ADD && !a_hit_ff && a_free_ff)
         akey_mem[a_fidx_ff] <= addr_ff;
   end
   always_ff @(posedge clock) begin
      if (cmd.finish && op_ff == OP_DENY_ADD && !d_hit_ff && d_free_ff)
         dkey_mem[d_fidx_ff] <= addr_ff;
   end

   // result next values
   logic             acc_in;
   logic [2:0]       st_in;
   logic [CNT_W-1:0] tot_in, ac_in;

   always_comb begin
      acc_in = 1'b0;
      st_in  = ST_OK;
      tot_in = total_ff;
      ac_in  = '0;
      case (op_ff)
         OP_OPEN: begin
            tot_in = tot_inc;
            if (per_on && c_hit_ff) ac_in = cv_inc;
            else if (per_on && c_free_ff) ac_in = CNT_W'(1);
            if (tot_inc > max_total) st_in = ST_TOTAL_OVER;
            else if (per_on && c_hit_ff && cv_inc > max_per && !a_hit_ff)
               st_in = ST_ADDR_OVER;
            else if (d_hit_ff) st_in = ST_DENIED;
            else begin
               acc_in = 1'b1;
               if (per_on && !c_hit_ff && !c_free_ff) st_in = ST_TABLE_FULL;
            end
         end
         OP_CLOSE: begin
            tot_in = tot_dec;
            if (per_on && !c_hit_ff) st_in = ST_NOT_FOUND;
            else acc_in = 1'b1;
            if (per_on && c_hit_ff) ac_in = cv_dec;
         end
         OP_ALLOW_ADD: begin
            if (a_hit_ff || a_free_ff) acc_in = 1'b1;
            else st_in = ST_TABLE_FULL;
         end
         OP_DENY_ADD: begin
            if (d_hit_ff || d_free_ff) acc_in = 1'b1;
            else st_in = ST_TABLE_FULL;
         end
         OP_ALLOW_REMOVE: begin
            if (a_hit_ff) acc_in = 1'b1;
            else st_in = ST_NOT_FOUND;
         end
         OP_DENY_REMOVE: begin
            if (d_hit_ff) acc_in = 1'b1;
            else st_in = ST_NOT_FOUND;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_accepted   <= acc_in;
         out_status     <= st_in;
         out_total      <= tot_in;
         out_addr_count <= ac_in;
      end
   end
endmodule

// ===== rtl/cal_ctrl.sv =====
// Controller: sequences accept, table scan, commit and response handshake.
module cal_ctrl
   import cal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output cal_cmd_type cmd,
   input  cal_sts_type sts
);
   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;
   state_type state_ff;
   logic      rsp_vld_ff;
   logic      rsp_vld_in;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_vld_ff || rsp_tready);
   assign rsp_tvalid = rsp_vld_ff;

   always_comb begin
      cmd.start  = req_tvalid && req_tready;
      cmd.scan   = (state_ff == S_SCAN) && !sts.scan_done;
      cmd.finish = (state_ff == S_SCAN) && sts.scan_done && (!rsp_vld_ff || rsp_tready);
      // a new response wins over the one leaving in the same cycle
      if (cmd.finish) rsp_vld_in = 1'b1;
      else if (rsp_vld_ff && rsp_tready) rsp_vld_in = 1'b0;
      else rsp_vld_in = rsp_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         case (state_ff)
            S_IDLE: if (cmd.start) state_ff <= S_SCAN;
            S_SCAN: if (cmd.finish) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/connection_admission_limiter_top.sv =====
// Top level of the connection admission limiter.
// Each transaction is one operation on a peer address. The block scans the
// count table, allow list and deny list in parallel, one entry of each per
// cycle from their memories, until the deepest of the three is covered; the
// result is then committed into the response register. With the response
// taken at once the next request can be accepted in the cycle after the
// commit, so one transaction is in flight at a time.
// Responses sit in an output register, so the next request is taken as soon
// as the previous response is consumed or in the same cycle; a stalled
// response holds back the next request. Counts saturate at 0 and 65535.
// Configuration writes go in at any time and take effect at once; write
// only while no transaction is pending. Tables start empty after reset.
module connection_admission_limiter_top
   import cal_pkg::*;
#(
   parameter int COUNT_TABLE_DEPTH = COUNT_TABLE_DEPTH_DEF,
   parameter int ALLOW_DEPTH       = ALLOW_DEPTH_DEF,
   parameter int DENY_DEPTH        = DENY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] operation, [34:3] peer_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] accepted, [3:1] status,
                                    // [19:4] total_count, [35:20] address_count
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   cal_cmd_type cmd;
   cal_sts_type sts;
   logic [CNT_W-1:0] max_total_ff, max_per_ff;
   logic             acc;
   logic [2:0]       st;
   logic [CNT_W-1:0] tot, ac;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= CNT_MAX;
         max_per_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_TOTAL: max_total_ff <= csr_data;
            CSR_MAX_PER:   max_per_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   cal_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .sts
   );

   cal_datapath #(
      .COUNT_TABLE_DEPTH(COUNT_TABLE_DEPTH),
      .ALLOW_DEPTH(ALLOW_DEPTH),
      .DENY_DEPTH(DENY_DEPTH)
   ) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_op(req_tdata[2:0]),
      .req_addr(req_tdata[34:3]),
      .max_total(max_total_ff),
      .max_per(max_per_ff),
      .out_accepted(acc),
      .out_status(st),
      .out_total(tot),
      .out_addr_count(ac)
   );

   assign rsp_tdata = {4'b0, ac, tot, st, acc};
endmodule

// ===== rtl/cal_checker.sv =====
// Port-level checker for the connection admission limiter, bound to the top.
`include "connection_admission_limiter_top_macros.svh"
module cal_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   // accepted responses never carry a rejection reason
   `CAL_ASSERT_IMP(a_acc_status, clock, reset,
      rsp_tvalid && rsp_tdata[0],
      rsp_tdata[3:1] == 3'd0 || rsp_tdata[3:1] == 3'd4)
   // no request is accepted in the cycle right after an accepted one
   `CAL_ASSERT_NEXT(a_no_instant, clock, reset,
      req_tvalid && req_tready, !req_tready)
   // a stalled response holds
   `CAL_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // status codes stay in range
   `CAL_ASSERT_IMP(a_status_rng, clock, reset,
      rsp_tvalid, rsp_tdata[3:1] != 3'd6 && rsp_tdata[3:1] != 3'd7)
endmodule

bind connection_admission_limiter_top cal_port_checker u_cal_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
